// ===== hdl/subscription_table_assert.svh =====
// Assertion macros shared by the subscription table checkers.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef SUBSCRIPTION_TABLE_ASSERT_SVH
`define SUBSCRIPTION_TABLE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SUBTAB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SUBTAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/subtab_pkg.sv =====
// Shared types and constants of the subscription table.
// No dependencies; imported by subscription_table, the checker and the testbench files.
`default_nettype none

package subtab_pkg;

    localparam int KEY_W  = 64;
    localparam int ID_W   = 31;
    localparam int KIND_W = 2;
    localparam int STAT_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_SUB   = 2'd0,
        KIND_UNSUB = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_TABLE_FULL = 3'd1,
        ST_LIST_FULL  = 3'd2,
        ST_NO_KEY     = 3'd3,
        ST_NO_ID      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KSCAN,
        S_IDSCAN,
        S_MOVE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/subtab_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module subtab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/subscription_table.sv =====
// Subscription table: one operation per start, one result strobe on o_valid.
// Busy stays high while the key entries are read one by one and then the ids (a scan that
// misses reads one step past the last entry), plus a move step for an unsubscribe hit; the
// strobe comes as busy falls. A new start is taken in the strobe cycle at the earliest, so
// one operation finishes before the next is accepted. The receiver cannot stall the result.
// Synchronous active-low reset empties the table (key count zero); memories are not cleared.
`default_nettype none

module subscription_table
    import subtab_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BYTES   = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [ID_W-1:0]   i_subscriber_id,
    output logic                   o_valid,
    output logic [STAT_W-1:0]      o_status,
    output logic                   o_is_member
);

    localparam int KCW = $clog2(MAX_ENTRIES + 1);
    localparam int SW  = $clog2(MAX_ENTRIES);
    localparam int IAW = $clog2(MAX_ENTRIES * MAX_ENTRIES);
    localparam int KEW = KEY_W + KCW;

    function automatic logic [IAW-1:0] id_addr(input logic [SW-1:0] slot,
                                               input logic [KCW-1:0] idx);
        return IAW'(slot) * IAW'(MAX_ENTRIES) + IAW'(idx);
    endfunction

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [ID_W-1:0]    r_id, n_id;
    logic [KCW-1:0]     r_idx, n_idx;
    logic [KCW-1:0]     r_len, n_len;
    logic [KCW-1:0]     r_count, n_count;
    logic [SW-1:0]      r_slot, n_slot;
    logic [SW-1:0]      r_pos, n_pos;
    logic               r_valid, n_valid;
    t_status            r_status, n_status;
    logic               r_member, n_member;

    logic [KEY_W-1:0]   w_canon;
    logic               w_keep;

    logic               k_we;
    logic [SW-1:0]      k_waddr;
    logic [KEW-1:0]     k_wdata;
    logic [KEW-1:0]     k_rdata;
    logic               id_we;
    logic [IAW-1:0]     id_waddr;
    logic [ID_W-1:0]    id_wdata;
    logic [ID_W-1:0]    id_rdata;
    logic [KEY_W-1:0]   w_rd_key;
    logic [KCW-1:0]     w_rd_len;

    // Key table: list length in the upper bits, canonical key below.
    subtab_ram #(.WIDTH(KEW), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (k_wdata),
        .i_raddr (n_idx[SW-1:0]),
        .o_rdata (k_rdata)
    );

    subtab_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES * MAX_ENTRIES)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (id_waddr),
        .i_wdata (id_wdata),
        .i_raddr (id_addr(n_slot, n_idx)),
        .o_rdata (id_rdata)
    );

    assign w_rd_key = k_rdata[KEY_W-1:0];
    assign w_rd_len = k_rdata[KEW-1:KEY_W];

    // Keep bytes up to the first zero byte, within KEY_BYTES.
    always_comb begin
        w_canon = '0;
        w_keep  = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b < KEY_BYTES && w_keep && i_key[8*b +: 8] != 8'd0) begin
                w_canon[8*b +: 8] = i_key[8*b +: 8];
            end else begin
                w_keep = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_key    <= n_key;
        r_id     <= n_id;
        r_idx    <= n_idx;
        r_len    <= n_len;
        r_slot   <= n_slot;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_member <= n_member;
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_key    = r_key;
        n_id     = r_id;
        n_idx    = r_idx;
        n_len    = r_len;
        n_count  = r_count;
        n_slot   = r_slot;
        n_pos    = r_pos;
        n_valid  = 1'b0;
        n_status = r_status;
        n_member = 1'b0;
        k_we     = 1'b0;
        k_waddr  = r_slot;
        k_wdata  = {r_len, r_key};
        id_we    = 1'b0;
        id_waddr = id_addr(r_slot, r_len);
        id_wdata = r_id;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind  = t_kind'(i_kind);
                    n_key   = w_canon;
                    n_id    = i_subscriber_id;
                    n_idx   = '0;
                    n_state = S_KSCAN;
                end
            end

            S_KSCAN: begin
                if (r_idx == r_count) begin
                    // Key absent
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_status = ST_OK;
                    case (r_kind)
                        KIND_SUB: begin
                            if (r_count == KCW'(MAX_ENTRIES)) begin
                                n_status = ST_TABLE_FULL;
                            end else begin
                                k_we     = 1'b1;
                                k_waddr  = r_count[SW-1:0];
                                k_wdata  = {KCW'(1), r_key};
                                id_we    = 1'b1;
                                id_waddr = id_addr(r_count[SW-1:0], '0);
                                n_count  = r_count + KCW'(1);
                            end
                        end
                        KIND_UNSUB, KIND_QUERY: n_status = ST_NO_KEY;
                        default: n_status = ST_OK;
                    endcase
                end else if (w_rd_key == r_key) begin
                    n_slot = r_idx[SW-1:0];
                    n_len  = w_rd_len;
                    case (r_kind)
                        KIND_SUB: begin
                            n_state  = S_IDLE;
                            n_valid  = 1'b1;
                            n_status = ST_OK;
                            if (w_rd_len == KCW'(MAX_ENTRIES)) begin
                                n_status = ST_LIST_FULL;
                            end else begin
                                k_we     = 1'b1;
                                k_waddr  = r_idx[SW-1:0];
                                k_wdata  = {w_rd_len + KCW'(1), r_key};
                                id_we    = 1'b1;
                                id_waddr = id_addr(r_idx[SW-1:0], w_rd_len);
                            end
                        end
                        KIND_UNSUB, KIND_QUERY: begin
                            n_idx   = '0;
                            n_state = S_IDSCAN;
                        end
                        default: begin
                            n_state  = S_IDLE;
                            n_valid  = 1'b1;
                            n_status = ST_OK;
                        end
                    endcase
                end else begin
                    n_idx = r_idx + KCW'(1);
                end
            end

            S_IDSCAN: begin
                if (r_idx == r_len) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_NO_ID;
                end else if (id_rdata == r_id) begin
                    if (r_kind == KIND_QUERY) begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_member = 1'b1;
                    end else begin
                        // Fetch the last id to fill the gap
                        n_pos   = r_idx[SW-1:0];
                        n_idx   = r_len - KCW'(1);
                        n_state = S_MOVE;
                    end
                end else begin
                    n_idx = r_idx + KCW'(1);
                end
            end

            S_MOVE: begin
                id_we    = 1'b1;
                id_waddr = id_addr(r_slot, KCW'(r_pos));
                id_wdata = id_rdata;
                k_we     = 1'b1;
                k_waddr  = r_slot;
                k_wdata  = {r_len - KCW'(1), r_key};
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_status = ST_OK;
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_is_member = r_member;

endmodule

`default_nettype wire

// ===== hdl/subtab_checker.sv =====
// Port-level checker for the subscription table, bound to the top level.
// Depends on subtab_pkg and subscription_table_assert.svh.
`default_nettype none

`include "subscription_table_assert.svh"

module subtab_checker
    import subtab_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_valid,
    input wire logic [STAT_W-1:0] o_status,
    input wire logic              o_is_member
);

    `SUBTAB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted beat did not raise busy")
    `SUBTAB_ASSERT_SAME(a_done_on_fall, i_clk, i_rst_n, $fell(busy), o_valid, "busy fell without a result")
    `SUBTAB_ASSERT_NEXT(a_one_strobe, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `SUBTAB_ASSERT_SAME(a_member_ok, i_clk, i_rst_n, o_valid && o_is_member, o_status == ST_OK, "member reported with error status")
    `SUBTAB_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_valid, o_status == ST_OK || o_status == ST_TABLE_FULL || o_status == ST_LIST_FULL || o_status == ST_NO_KEY || o_status == ST_NO_ID, "undefined status code")

endmodule

bind subscription_table subtab_checker u_subtab_checker (.*);

`default_nettype wire

// ===== sim/subtab_ledger_pkg.sv =====
// Scoreboard of the subscription table testbench: predicts the reply to each accepted
// operation and checks the replies in order. Depends on subtab_pkg.
package subtab_ledger_pkg;
    import subtab_pkg::*;

    localparam int TOPIC_SLOTS = 16;
    localparam int TOPIC_BYTES = 8;

    typedef struct {
        t_status status;
        logic    is_member;
    } reply_t;

    class topic_ledger;
        logic [KEY_W-1:0] topic_keys [TOPIC_SLOTS];
        logic [ID_W-1:0]  roster [TOPIC_SLOTS][TOPIC_SLOTS];
        int               roster_len [TOPIC_SLOTS];
        int               topic_count;
        reply_t           pending_replies [$];
        int               errors;
        int               accepted;
        int               status_tally [5];
        int               member_hits;

        function int find_member(int slot, logic [ID_W-1:0] id);
            for (int i = 0; i < roster_len[slot]; i++) begin
                if (roster[slot][i] == id) return i;
            end
            return -1;
        endfunction

        // Apply one accepted operation to the table copy and queue its reply.
        function void record_request(t_kind kind, logic [KEY_W-1:0] key,
                                     logic [ID_W-1:0] id);
            logic [KEY_W-1:0] name;
            int               slot;
            int               pos;
            reply_t           want;
            // the name ends at the first zero byte; anything past it is ignored
            name = '0;
            for (int b = 0; b < TOPIC_BYTES; b++) begin
                if (key[8*b +: 8] == 8'h00) break;
                name[8*b +: 8] = key[8*b +: 8];
            end
            slot = -1;
            for (int i = 0; i < topic_count; i++) begin
                if (topic_keys[i] == name) begin
                    slot = i;
                    break;
                end
            end
            want.status    = ST_OK;
            want.is_member = 1'b0;
            case (kind)
                KIND_SUB: begin
                    if (slot < 0) begin
                        if (topic_count >= TOPIC_SLOTS) begin
                            want.status = ST_TABLE_FULL;
                        end else begin
                            slot = topic_count;
                            topic_keys[slot] = name;
                            roster_len[slot] = 0;
                            topic_count++;
                        end
                    end
                    if (slot >= 0) begin
                        if (roster_len[slot] >= TOPIC_SLOTS) begin
                            want.status = ST_LIST_FULL;
                        end else begin
                            roster[slot][roster_len[slot]] = id;
                            roster_len[slot]++;
                        end
                    end
                end
                KIND_UNSUB: begin
                    if (slot < 0) begin
                        want.status = ST_NO_KEY;
                    end else begin
                        pos = find_member(slot, id);
                        if (pos < 0) begin
                            want.status = ST_NO_ID;
                        end else begin
                            // move the last id into the hole
                            roster_len[slot]--;
                            roster[slot][pos] = roster[slot][roster_len[slot]];
                        end
                    end
                end
                KIND_QUERY: begin
                    if (slot < 0) begin
                        want.status = ST_NO_KEY;
                    end else if (find_member(slot, id) < 0) begin
                        want.status = ST_NO_ID;
                    end else begin
                        want.is_member = 1'b1;
                    end
                end
                default: ;
            endcase
            accepted++;
            status_tally[int'(want.status)]++;
            if (want.is_member) member_hits++;
            pending_replies.push_back(want);
        endfunction

        function void check_reply(logic [STAT_W-1:0] status, logic is_member);
            reply_t want;
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with none outstanding: status %0d is_member %0b",
                         $time, status, is_member);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                errors++;
            end
            if (is_member !== want.is_member) begin
                $display("%0t: is_member mismatch: expected %0b, actual %0b",
                         $time, want.is_member, is_member);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== sim/tb_subscription_table.sv =====
// Top-level testbench of subscription_table: drives operations through start/busy
// and checks every result strobe. Depends on subtab_pkg and subtab_ledger_pkg.
module tb_subscription_table;
    timeunit 1ns;
    timeprecision 1ps;

    import subtab_pkg::*;
    import subtab_ledger_pkg::*;

    localparam int POOL_SIZE = 24;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [KIND_W-1:0] i_kind = '0;
    logic [KEY_W-1:0]  i_key = '0;
    logic [ID_W-1:0]   i_subscriber_id = '0;
    logic              busy;
    logic              o_valid;
    logic [STAT_W-1:0] o_status;
    logic              o_is_member;

    topic_ledger       ledger = new();
    logic [KEY_W-1:0]  topic_pool [POOL_SIZE];
    int                pool_len [POOL_SIZE];
    int                idle_pct;
    int                sent;

    subscription_table #(
        .MAX_ENTRIES (TOPIC_SLOTS),
        .KEY_BYTES   (TOPIC_BYTES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_key           (i_key),
        .i_subscriber_id (i_subscriber_id),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_is_member     (o_is_member)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Timeout: %0d replies still outstanding", ledger.pending_replies.size());
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) ledger.check_reply(o_status, o_is_member);
    end

    // Pool name, optionally with junk bytes past its terminating zero.
    function automatic logic [KEY_W-1:0] dress_key(int n);
        logic [KEY_W-1:0] k;
        k = topic_pool[n];
        if (pool_len[n] < 7 && $urandom_range(1) == 1)
            k = k | ({$urandom, $urandom} << (8 * (pool_len[n] + 1)));
        return k;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(4) == 0) return ID_W'($urandom);
        return ID_W'($urandom_range(15));
    endfunction

    task automatic send_op(input t_kind kind, input logic [KEY_W-1:0] key,
                           input logic [ID_W-1:0] id);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 40) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_kind          <= kind;
        i_key           <= key;
        i_subscriber_id <= id;
        do @(posedge i_clk); while (busy !== 1'b0);
        ledger.record_request(kind, key, id);
        if (kind != KIND_NONE) sent++;
    endtask

    task automatic random_phase(input int pct, input int quota);
        int               stop;
        int               pick;
        int               hot;
        t_kind            kind;
        logic [KEY_W-1:0] key;
        idle_pct = pct;
        stop = sent + quota;
        while (sent < stop) begin
            pick = $urandom_range(99);
            hot  = $urandom_range(3);
            if (pick < 6) begin
                // push one busy topic toward and past its list limit
                repeat ($urandom_range(6, 18)) send_op(KIND_SUB, dress_key(hot), pick_id());
            end else if (pick < 12) begin
                repeat ($urandom_range(4, 12)) send_op(KIND_UNSUB, dress_key(hot), pick_id());
            end else begin
                pick = $urandom_range(99);
                if (pick < 40) kind = KIND_SUB;
                else if (pick < 65) kind = KIND_UNSUB;
                else if (pick < 95) kind = KIND_QUERY;
                else kind = KIND_NONE;
                if ($urandom_range(9) == 0) key = {$urandom, $urandom};
                else key = dress_key($urandom_range(POOL_SIZE - 1));
                send_op(kind, key, pick_id());
            end
        end
    endtask

    initial begin
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_c;
        for (int n = 0; n < POOL_SIZE; n++) begin
            pool_len[n] = (n == 0) ? 0 : (n == 1) ? 8 : (n == 2) ? 3 : $urandom_range(1, 8);
            topic_pool[n] = '0;
            for (int b = 0; b < pool_len[n]; b++)
                topic_pool[n][8*b +: 8] = 8'($urandom_range(1, 255));
        end
        key_a = topic_pool[1];
        key_c = topic_pool[2];
        idle_pct = 30;
        sent = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_op(KIND_QUERY, key_a, 31'd5);          // unknown topic
        send_op(KIND_UNSUB, key_a, 31'd5);
        send_op(KIND_SUB,   key_a, '0);
        send_op(KIND_SUB,   key_a, '1);
        send_op(KIND_SUB,   key_a, '0);             // duplicate id
        send_op(KIND_QUERY, key_a, '1);
        send_op(KIND_QUERY, key_a, 31'd1);          // known topic, id absent
        send_op(KIND_UNSUB, key_a, 31'd1);
        send_op(KIND_UNSUB, key_a, '0);             // last id fills the hole
        send_op(KIND_QUERY, key_a, '0);
        send_op(KIND_QUERY, key_a, '1);
        send_op(KIND_SUB,   '0, 31'd3);             // empty name
        send_op(KIND_SUB,   64'hFFFF_FFFF_FFFF_FF00, 31'd4);
        send_op(KIND_QUERY, '0, 31'd4);
        send_op(KIND_SUB,   key_c | 64'hA5C3_0F00_0000_0000, 31'd7);
        send_op(KIND_QUERY, key_c, 31'd7);
        send_op(KIND_UNSUB, key_c | 64'hFFFF_FFFF_0000_0000, 31'd7);
        send_op(KIND_QUERY, key_c, 31'd7);
        send_op(KIND_SUB,   '1, 31'h4000_0000);
        send_op(KIND_QUERY, '1, 31'h4000_0000);
        send_op(KIND_NONE,  '1, '1);
        send_op(KIND_NONE,  '0, '0);

        random_phase(30, 160);
        random_phase(88, 160);
        random_phase(0, 160);
        start <= 1'b0;

        while (ledger.pending_replies.size() != 0) @(posedge i_clk);
        repeat (2 * TOPIC_SLOTS + 8) @(posedge i_clk);

        $display("Covered %0d operations over three idle mixes, %0d topics in use, %0d hits.",
                 ledger.accepted, ledger.topic_count, ledger.member_hits);
        $display("Replies: ok %0d, table full %0d, list full %0d, no topic %0d, no id %0d",
                 ledger.status_tally[0], ledger.status_tally[1], ledger.status_tally[2],
                 ledger.status_tally[3], ledger.status_tally[4]);
        if (ledger.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/subtab_pkg.sv
hdl/subtab_ram.sv
hdl/subscription_table.sv
hdl/subtab_checker.sv
sim/subtab_ledger_pkg.sv
sim/tb_subscription_table.sv
